// ===== src/rpt_pkg.sv =====
`timescale 1ns / 1ps

package rpt_pkg;

  localparam logic [7:0] THRESHOLD_RESET = 8'd100;

  // Number of result slots in the output queue.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       end_of_row;
    logic       last_of_burst;
  } result_t;

  // Up to two results produced by one item, in delivery order.
  typedef struct packed {
    logic    vld0;
    result_t res0;
    logic    vld1;
    result_t res1;
  } push_t;

endpackage

// ===== src/rpt_core.sv =====
`timescale 1ns / 1ps

module rpt_core
  import rpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       item_fire,
  input  logic [7:0] item_pixel,
  input  logic       item_first,
  input  logic       item_last,
  output logic [1:0] item_nres,
  output push_t      push
);

  logic [7:0] thr_r;
  logic [7:0] prev_r, prev_nxt;
  logic [7:0] max_r, max_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic       pend_vld_r, pend_vld_nxt;

  logic [7:0] prev_eff;
  logic [7:0] max_eff;
  logic [7:0] result;
  logic       above;
  logic       below;
  logic       clear_pend;

  // Results this item will produce: the pending pixel, plus the pixel itself at a row end.
  assign item_nres = {1'b0, pend_vld_r} + {1'b0, item_last};

  always_comb begin
    prev_eff   = item_first ? 8'd0 : prev_r;
    max_eff    = item_first ? 8'd0 : max_r;
    above      = item_pixel > thr_r;
    below      = item_pixel < thr_r;
    result     = 8'd0;
    clear_pend = 1'b0;
    prev_nxt   = prev_eff;
    max_nxt    = max_eff;

    if (above && (item_pixel > max_eff)) begin
      result     = item_pixel;
      clear_pend = prev_eff != 8'd0;
      prev_nxt   = item_pixel;
      max_nxt    = item_pixel;
    end else if (above && (item_pixel < max_eff) && (prev_eff != 8'd0)) begin
      prev_nxt = item_pixel;
    end else if (below && (prev_eff != 8'd0)) begin
      prev_nxt = 8'd0;
      max_nxt  = 8'd0;
    end

    push.vld0               = pend_vld_r;
    push.res0.pixel_out     = clear_pend ? 8'd0 : pend_r;
    push.res0.end_of_row    = item_first;
    push.res0.last_of_burst = !item_last;
    push.vld1               = item_last;
    push.res1.pixel_out     = result;
    push.res1.end_of_row    = 1'b1;
    push.res1.last_of_burst = 1'b1;

    if (item_last) begin
      // A row end delivers the pixel at once and starts the next row afresh.
      prev_nxt     = 8'd0;
      max_nxt      = 8'd0;
      pend_nxt     = 8'd0;
      pend_vld_nxt = 1'b0;
    end else begin
      pend_nxt     = result;
      pend_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THRESHOLD_RESET;
      prev_r     <= 8'd0;
      max_r      <= 8'd0;
      pend_r     <= 8'd0;
      pend_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (item_fire) begin
        prev_r     <= prev_nxt;
        max_r      <= max_nxt;
        pend_r     <= pend_nxt;
        pend_vld_r <= pend_vld_nxt;
      end
    end
  end

endmodule

// ===== src/rpt_out_queue.sv =====
`timescale 1ns / 1ps

module rpt_out_queue
  import rpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_en,
  input  push_t      push,
  input  logic       out_ready,
  output logic       out_valid,
  output result_t    head,
  output logic [1:0] count
);

  result_t    q_r   [QUEUE_DEPTH];
  result_t    q_nxt [QUEUE_DEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = cnt_r != 2'd0;
  assign head      = q_r[0];
  assign count     = cnt_r;
  assign pop       = out_valid && out_ready;

  // Pop shifts the second slot forward; pushes then append behind what is left.
  // The caller only pushes when all of an item's results fit, so the append slot is 0 or 1.
  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      cnt_nxt  = cnt_r - 2'd1;
    end
    if (push_en && push.vld0) begin
      q_nxt[cnt_nxt[0]] = push.res0;
      cnt_nxt           = cnt_nxt + 2'd1;
    end
    if (push_en && push.vld1) begin
      q_nxt[cnt_nxt[0]] = push.res1;
      cnt_nxt           = cnt_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/row_peak_thinning_top.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    in_pixel_in[7:0], in_row_first, in_row_last
// out       output     out_valid/out_ready  out_pixel_out[7:0], out_end_of_row,
//                                           out_last_of_burst
// cfg       input      cfg_wr_en            cfg_wr_data[7:0] (threshold)
//
// An item is taken on every clock while the two-slot output queue has room for its results.
// Results released by an accepted item pass through the input register and then the output queue
// before they show on the out ports; a kept pixel itself waits for the following item of its row,
// or leaves at once at a row end. A row-end item that also flushes a pending pixel needs both
// slots, so the input register holds it until the queue is empty. in_ready never uses out_ready.
// Reset (rst_n low, synchronous) empties both registers and restores threshold to 100.

module row_peak_thinning_top
  import rpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_pixel_in,
  input  logic       in_row_first,
  input  logic       in_row_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_pixel_out,
  output logic       out_end_of_row,
  output logic       out_last_of_burst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic       in_vld_r;
  logic [7:0] in_pix_r;
  logic       in_first_r;
  logic       in_last_r;
  logic [1:0] nres;
  logic [1:0] q_count;
  logic       fire;
  push_t      push;
  result_t    head;

  // The held item is processed once all of its results fit in the queue.
  assign fire     = in_vld_r && (({1'b0, q_count} + {1'b0, nres}) <= 3'd2);
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_pix_r   <= in_pixel_in;
      in_first_r <= in_row_first;
      in_last_r  <= in_row_last;
    end
  end

  rpt_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_fire   (fire),
    .item_pixel  (in_pix_r),
    .item_first  (in_first_r),
    .item_last   (in_last_r),
    .item_nres   (nres),
    .push        (push)
  );

  rpt_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (fire),
    .push      (push),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign out_pixel_out     = head.pixel_out;
  assign out_end_of_row    = head.end_of_row;
  assign out_last_of_burst = head.last_of_burst;

endmodule

// ===== src/rpt_checker.sv =====
`timescale 1ns / 1ps

module rpt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pixel_out,
  input logic       out_end_of_row,
  input logic       out_last_of_burst
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_out) && $stable(out_end_of_row)
      && $stable(out_last_of_burst))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  // A result that is not the last of its item is a flushed pixel; the row-end pixel
  // of the same item is already queued behind it.
  a_burst_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_burst |=> out_valid && out_end_of_row
      && out_last_of_burst)
    else $error("second result of an item missing");

endmodule

bind row_peak_thinning_top rpt_checker u_rpt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_pixel_out     (out_pixel_out),
  .out_end_of_row    (out_end_of_row),
  .out_last_of_burst (out_last_of_burst)
);
